// ===== src/csmab_pkg.sv =====
`default_nettype none
package csmab_pkg;

	// Width of the gap, jam and backoff countdown
	localparam int COUNT_WIDTH = 20;

	localparam int DRAW_W   = 10;
	localparam int LEN_W    = 10;
	localparam int TAIL_W   = 12;
	localparam int LIMIT_W  = 5;
	localparam int CAP_W    = 4;
	localparam int PHASE_W  = 3;
	localparam int ATT_W    = 5;
	localparam int PROG_W   = 13;
	localparam int PROD_W   = DRAW_W + LEN_W;
	localparam int CNT_EXT_W = ((PROD_W > COUNT_WIDTH) ? PROD_W : COUNT_WIDTH) + 1;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	// Phase codes as shown on the result stream
	localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_LISTEN  = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_TX      = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_JAM     = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_BACKOFF = 3'd4;

	// Register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_GAP   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_JAM   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SLOT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPAN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TAIL  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CAP   = 3'd6;

	// Register reset values
	localparam logic [LEN_W-1:0]   GAP_RST   = 10'd96;
	localparam logic [LEN_W-1:0]   JAM_RST   = 10'd148;
	localparam logic [LEN_W-1:0]   SLOT_RST  = 10'd200;
	localparam logic [LEN_W-1:0]   SPAN_RST  = 10'd100;
	localparam logic [TAIL_W-1:0]  TAIL_RST  = 12'd576;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;
	localparam logic [CAP_W-1:0]   CAP_RST   = 4'd10;

	localparam logic [ATT_W-1:0] ATT_MAX = 5'd31;

	typedef struct packed {
		logic [LEN_W-1:0]   gap_bits;
		logic [LEN_W-1:0]   jam_bits;
		logic [LEN_W-1:0]   slot_bits;
		logic [LEN_W-1:0]   span_bits;
		logic [TAIL_W-1:0]  tail_bits;
		logic [LIMIT_W-1:0] attempt_limit;
		logic [CAP_W-1:0]   exponent_cap;
	} cfg_t;

	typedef struct packed {
		logic [DRAW_W-1:0] random_draw;
		logic              carrier_sensed;
		logic              frame_waiting;
	} item_t;

	typedef struct packed {
		logic [ATT_W-1:0]   attempt_count;
		logic               gave_up;
		logic               sent_ok;
		logic               transmitting;
		logic [PHASE_W-1:0] phase;
	} result_t;

endpackage
`default_nettype wire

// ===== src/csmab_cfg.sv =====
`default_nettype none
module csmab_cfg (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [csmab_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire logic [csmab_pkg::APB_DATA_W-1:0]      pwdata,
	output logic      [csmab_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                       pready,
	output csmab_pkg::cfg_t                            cfg
);

	csmab_pkg::cfg_t                     cfg_q;
	logic [csmab_pkg::REG_IDX_W-1:0]     idx;
	logic                                wr_en;

	assign idx    = paddr[csmab_pkg::APB_ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_bits      <= csmab_pkg::GAP_RST;
			cfg_q.jam_bits      <= csmab_pkg::JAM_RST;
			cfg_q.slot_bits     <= csmab_pkg::SLOT_RST;
			cfg_q.span_bits     <= csmab_pkg::SPAN_RST;
			cfg_q.tail_bits     <= csmab_pkg::TAIL_RST;
			cfg_q.attempt_limit <= csmab_pkg::LIMIT_RST;
			cfg_q.exponent_cap  <= csmab_pkg::CAP_RST;
		end else if (wr_en) begin
			unique case (idx)
				csmab_pkg::REG_GAP:   cfg_q.gap_bits      <= pwdata[csmab_pkg::LEN_W-1:0];
				csmab_pkg::REG_JAM:   cfg_q.jam_bits      <= pwdata[csmab_pkg::LEN_W-1:0];
				csmab_pkg::REG_SLOT:  cfg_q.slot_bits     <= pwdata[csmab_pkg::LEN_W-1:0];
				csmab_pkg::REG_SPAN:  cfg_q.span_bits     <= pwdata[csmab_pkg::LEN_W-1:0];
				csmab_pkg::REG_TAIL:  cfg_q.tail_bits     <= pwdata[csmab_pkg::TAIL_W-1:0];
				csmab_pkg::REG_LIMIT: cfg_q.attempt_limit <= pwdata[csmab_pkg::LIMIT_W-1:0];
				csmab_pkg::REG_CAP:   cfg_q.exponent_cap  <= pwdata[csmab_pkg::CAP_W-1:0];
				default: begin
					// no register here: drop the write
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			csmab_pkg::REG_GAP:   prdata = csmab_pkg::APB_DATA_W'(cfg_q.gap_bits);
			csmab_pkg::REG_JAM:   prdata = csmab_pkg::APB_DATA_W'(cfg_q.jam_bits);
			csmab_pkg::REG_SLOT:  prdata = csmab_pkg::APB_DATA_W'(cfg_q.slot_bits);
			csmab_pkg::REG_SPAN:  prdata = csmab_pkg::APB_DATA_W'(cfg_q.span_bits);
			csmab_pkg::REG_TAIL:  prdata = csmab_pkg::APB_DATA_W'(cfg_q.tail_bits);
			csmab_pkg::REG_LIMIT: prdata = csmab_pkg::APB_DATA_W'(cfg_q.attempt_limit);
			csmab_pkg::REG_CAP:   prdata = csmab_pkg::APB_DATA_W'(cfg_q.exponent_cap);
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/csmab_fsm.sv =====
`default_nettype none
module csmab_fsm (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire csmab_pkg::item_t  item_s1,
	input  wire csmab_pkg::cfg_t   cfg,
	output csmab_pkg::result_t     result_q
);

	typedef enum logic [csmab_pkg::PHASE_W-1:0] {
		ST_IDLE    = csmab_pkg::PHASE_IDLE,
		ST_LISTEN  = csmab_pkg::PHASE_LISTEN,
		ST_TX      = csmab_pkg::PHASE_TX,
		ST_JAM     = csmab_pkg::PHASE_JAM,
		ST_BACKOFF = csmab_pkg::PHASE_BACKOFF
	} state_t;

	state_t                                state_q, state_d;
	logic [csmab_pkg::COUNT_WIDTH-1:0]     cnt_q, cnt_d, cnt_tick, gap_load, jam_load, backoff_len;
	logic [csmab_pkg::PROG_W-1:0]          prog_q, prog_d, prog_inc, frame_len;
	logic [csmab_pkg::ATT_W-1:0]           att_q, att_d, exp_k;
	logic                                  tick_done, sent_ok, gave_up;
	logic [csmab_pkg::DRAW_W-1:0]          draw_mask, slots;
	logic [csmab_pkg::PROD_W-1:0]          prod;
	logic [csmab_pkg::CNT_EXT_W-1:0]       prod_ext, cnt_max_ext;

	assign tick_done = (cnt_q <= csmab_pkg::COUNT_WIDTH'(1));
	assign cnt_tick  = tick_done ? '0 : cnt_q - csmab_pkg::COUNT_WIDTH'(1);
	assign gap_load  = csmab_pkg::COUNT_WIDTH'(cfg.gap_bits);
	assign jam_load  = csmab_pkg::COUNT_WIDTH'(cfg.jam_bits);
	assign prog_inc  = prog_q + csmab_pkg::PROG_W'(1);
	assign frame_len = csmab_pkg::PROG_W'(cfg.span_bits) + csmab_pkg::PROG_W'(cfg.tail_bits);

	// Backoff slots: draw masked to min(attempts, cap) low bits
	assign exp_k = (att_q < csmab_pkg::ATT_W'(cfg.exponent_cap)) ? att_q
		: csmab_pkg::ATT_W'(cfg.exponent_cap);

	always_comb begin
		for (int i = 0; i < csmab_pkg::DRAW_W; i++) begin
			draw_mask[i] = (csmab_pkg::ATT_W'(i) < exp_k);
		end
	end

	assign slots       = item_s1.random_draw & draw_mask;
	assign prod        = csmab_pkg::PROD_W'(slots) * csmab_pkg::PROD_W'(cfg.slot_bits);
	assign prod_ext    = csmab_pkg::CNT_EXT_W'(prod);
	assign cnt_max_ext = (csmab_pkg::CNT_EXT_W'(1) << csmab_pkg::COUNT_WIDTH)
		- csmab_pkg::CNT_EXT_W'(1);
	// Saturate a length that overflows the countdown
	assign backoff_len = (prod_ext > cnt_max_ext) ? '1
		: prod_ext[csmab_pkg::COUNT_WIDTH-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		prog_d  = prog_q;
		att_d   = att_q;
		sent_ok = 1'b0;
		gave_up = 1'b0;
		unique case (state_q)
			ST_LISTEN: begin
				if (item_s1.carrier_sensed) begin
					cnt_d = gap_load;
				end else begin
					cnt_d = cnt_tick;
					if (tick_done) begin
						state_d = ST_TX;
						prog_d  = '0;
					end
				end
			end
			ST_TX: begin
				if ((prog_q < csmab_pkg::PROG_W'(cfg.span_bits)) && item_s1.carrier_sensed) begin
					att_d   = (att_q != csmab_pkg::ATT_MAX) ? att_q + csmab_pkg::ATT_W'(1)
						: att_q;
					state_d = ST_JAM;
					cnt_d   = jam_load;
					prog_d  = '0;
				end else begin
					prog_d = prog_inc;
					if (prog_inc >= frame_len) begin
						sent_ok = 1'b1;
						att_d   = '0;
						prog_d  = '0;
						state_d = ST_IDLE;
					end
				end
			end
			ST_JAM: begin
				cnt_d = cnt_tick;
				if (tick_done) begin
					if (att_q >= cfg.attempt_limit) begin
						gave_up = 1'b1;
						att_d   = '0;
						state_d = ST_IDLE;
					end else if (backoff_len == '0) begin
						state_d = ST_LISTEN;
						cnt_d   = gap_load;
					end else begin
						state_d = ST_BACKOFF;
						cnt_d   = backoff_len;
					end
				end
			end
			ST_BACKOFF: begin
				cnt_d = cnt_tick;
				if (tick_done) begin
					state_d = ST_LISTEN;
					cnt_d   = gap_load;
				end
			end
			default: begin
				state_d = ST_IDLE;
				if (item_s1.frame_waiting) begin
					state_d = ST_LISTEN;
					cnt_d   = gap_load;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			prog_q   <= '0;
			att_q    <= '0;
			result_q <= '0;
		end else if (advance) begin
			state_q                <= state_d;
			cnt_q                  <= cnt_d;
			prog_q                 <= prog_d;
			att_q                  <= att_d;
			result_q.phase         <= state_d;
			result_q.transmitting  <= (state_d == ST_TX);
			result_q.sent_ok       <= sent_ok;
			result_q.gave_up       <= gave_up;
			result_q.attempt_count <= att_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/csma_cd_transmit_backoff.sv =====
`default_nettype none
// Channel   Dir  Handshake                    Payload
// s_*       in   s_tvalid / s_tready          s_tdata: one bit time of line status
// m_*       out  m_tvalid / m_tready          m_tdata: phase and status after that bit
// APB       in   psel, penable, pwrite, pready  seven config registers at 4*index
//
// One bit time is accepted every cycle unless a stalled m_tready holds the output; its result
// passes the input register, then the result register fed by the state update.
// The state update is the single combinational next-state pass.
// A stalled m_tready holds the result register; the input register keeps
// taking one more transaction and then s_tready drops until the result drains.
// Reset (arst_n low) loads register defaults and returns the state to idle.
module csma_cd_transmit_backoff (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [0] frame_waiting, [1] carrier_sensed, [11:2] random_draw, [15:12] zero
	input  wire logic [csmab_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [2:0] phase, [3] transmitting, [4] sent_ok, [5] gave_up,
	// [10:6] attempt_count, [15:11] zero
	output logic      [csmab_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [csmab_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [csmab_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [csmab_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                      pready
);

	csmab_pkg::cfg_t     cfg;
	csmab_pkg::item_t    item_s1;
	csmab_pkg::result_t  result_q;
	logic                valid_s1;
	logic                out_valid_q;
	logic                advance;

	csmab_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the held bit time whenever the result register is free or draining
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload register: no reset needed
	always_ff @(posedge clk) begin
		if (s_tready & s_tvalid) begin
			item_s1 <= s_tdata[$bits(csmab_pkg::item_t)-1:0];
		end
	end

	csmab_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item_s1  (item_s1),
		.cfg      (cfg),
		.result_q (result_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = csmab_pkg::OUT_DATA_W'(result_q);

endmodule
`default_nettype wire

// ===== src/csmab_checker.sv =====
`default_nettype none
module csmab_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic [csmab_pkg::OUT_DATA_W-1:0]     m_tdata
);

	csmab_pkg::result_t res;

	assign res = m_tdata[$bits(csmab_pkg::result_t)-1:0];

	// Transmit flag follows the phase code
	a_tx_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.transmitting == (res.phase == csmab_pkg::PHASE_TX)))
		else $error("transmitting disagrees with phase");

	// Completion and drop are exclusive, end in idle and clear the count
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res.sent_ok || res.gave_up)) |->
		(!(res.sent_ok && res.gave_up) && res.phase == csmab_pkg::PHASE_IDLE
		&& res.attempt_count == '0))
		else $error("bad completion or drop result");

	// A drop only follows a jam, so it cannot come right after a completion
	a_drop_after_jam: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && res.sent_ok) |=>
		(m_tvalid |-> !res.gave_up))
		else $error("drop right after a completion");

	// Held result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind csma_cd_transmit_backoff csmab_checker u_csmab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/csma_cd_backoff_checker.sv =====
`timescale 1ns / 100ps
module csma_cd_backoff_checker
	import csmab_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	input  wire logic [APB_DATA_W-1:0] prdata,
	output int                         pending,
	output int                         failures
);

	localparam int ITEM_W = $bits(item_t);
	localparam int STATUS_W = $bits(result_t);
	localparam logic [63:0] COUNT_CEIL = (64'd1 << COUNT_WIDTH) - 64'd1;

	// Shadow of the register file and of the transmitter state
	cfg_t               cfg;
	logic [PHASE_W-1:0] line_phase;
	logic [63:0]        count_left;
	logic [PROG_W-1:0]  bits_sent;
	logic [ATT_W-1:0]   collisions;

	result_t expected_status[$];

	task automatic flag(input string msg);
		failures++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic logic count_expired();
		if (count_left <= 64'd1) begin
			count_left = '0;
			return 1'b1;
		end
		count_left = count_left - 64'd1;
		return 1'b0;
	endfunction

	function automatic void enter_listen();
		line_phase = PHASE_LISTEN;
		count_left = 64'(cfg.gap_bits);
	endfunction

	function automatic result_t advance_bit_time(input item_t it);
		result_t          st;
		logic             ok;
		logic             drop;
		int unsigned      k;
		logic [31:0]      mask;
		logic [63:0]      slots;
		logic [63:0]      len;
		ok = 1'b0;
		drop = 1'b0;
		case (line_phase)
			PHASE_LISTEN: begin
				if (it.carrier_sensed) begin
					count_left = 64'(cfg.gap_bits);
				end else if (count_expired()) begin
					line_phase = PHASE_TX;
					bits_sent = '0;
				end
			end
			PHASE_TX: begin
				if (bits_sent < cfg.span_bits && it.carrier_sensed) begin
					if (collisions < ATT_MAX)
						collisions = collisions + 1'b1;
					line_phase = PHASE_JAM;
					count_left = 64'(cfg.jam_bits);
					bits_sent = '0;
				end else begin
					bits_sent = bits_sent + 1'b1;
					if (int'(bits_sent) >= int'(cfg.span_bits) + int'(cfg.tail_bits)) begin
						ok = 1'b1;
						collisions = '0;
						bits_sent = '0;
						line_phase = PHASE_IDLE;
					end
				end
			end
			PHASE_JAM: begin
				if (count_expired()) begin
					if (collisions >= cfg.attempt_limit) begin
						drop = 1'b1;
						collisions = '0;
						line_phase = PHASE_IDLE;
					end else begin
						k = (collisions < cfg.exponent_cap) ? 32'(collisions)
							: 32'(cfg.exponent_cap);
						mask = (32'd1 << k) - 32'd1;
						slots = 64'(it.random_draw & mask[DRAW_W-1:0]);
						len = slots * 64'(cfg.slot_bits);
						if (len > COUNT_CEIL)
							len = COUNT_CEIL;
						if (len == 64'd0) begin
							enter_listen();
						end else begin
							line_phase = PHASE_BACKOFF;
							count_left = len;
						end
					end
				end
			end
			PHASE_BACKOFF: begin
				if (count_expired())
					enter_listen();
			end
			default: begin
				line_phase = PHASE_IDLE;
				if (it.frame_waiting)
					enter_listen();
			end
		endcase
		st.phase = line_phase;
		st.transmitting = (line_phase == PHASE_TX);
		st.sent_ok = ok;
		st.gave_up = drop;
		st.attempt_count = collisions;
		return st;
	endfunction

	function automatic logic [APB_DATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
		logic [APB_DATA_W-1:0] v;
		v = '0;
		case (idx)
			REG_GAP:   v = APB_DATA_W'(cfg.gap_bits);
			REG_JAM:   v = APB_DATA_W'(cfg.jam_bits);
			REG_SLOT:  v = APB_DATA_W'(cfg.slot_bits);
			REG_SPAN:  v = APB_DATA_W'(cfg.span_bits);
			REG_TAIL:  v = APB_DATA_W'(cfg.tail_bits);
			REG_LIMIT: v = APB_DATA_W'(cfg.attempt_limit);
			REG_CAP:   v = APB_DATA_W'(cfg.exponent_cap);
			default:   v = 'x;
		endcase
		return v;
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] d);
		case (idx)
			REG_GAP:   cfg.gap_bits = d[LEN_W-1:0];
			REG_JAM:   cfg.jam_bits = d[LEN_W-1:0];
			REG_SLOT:  cfg.slot_bits = d[LEN_W-1:0];
			REG_SPAN:  cfg.span_bits = d[LEN_W-1:0];
			REG_TAIL:  cfg.tail_bits = d[TAIL_W-1:0];
			REG_LIMIT: cfg.attempt_limit = d[LIMIT_W-1:0];
			REG_CAP:   cfg.exponent_cap = d[CAP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_status(input logic [OUT_DATA_W-1:0] word);
		result_t want;
		result_t got;
		if (expected_status.size() == 0) begin
			flag($sformatf("result 0x%h with nothing expected", word));
		end else begin
			want = expected_status.pop_front();
			got = word[STATUS_W-1:0];
			if (got.phase !== want.phase)
				flag($sformatf("phase %0d, want %0d", got.phase, want.phase));
			if (got.transmitting !== want.transmitting)
				flag($sformatf("transmitting %b, want %b", got.transmitting, want.transmitting));
			if (got.sent_ok !== want.sent_ok)
				flag($sformatf("sent_ok %b, want %b", got.sent_ok, want.sent_ok));
			if (got.gave_up !== want.gave_up)
				flag($sformatf("gave_up %b, want %b", got.gave_up, want.gave_up));
			if (got.attempt_count !== want.attempt_count)
				flag($sformatf("attempt_count %0d, want %0d", got.attempt_count,
					want.attempt_count));
			if (word[OUT_DATA_W-1:STATUS_W] !== '0)
				flag($sformatf("padding bits 0x%h not zero", word[OUT_DATA_W-1:STATUS_W]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.gap_bits = GAP_RST;
			cfg.jam_bits = JAM_RST;
			cfg.slot_bits = SLOT_RST;
			cfg.span_bits = SPAN_RST;
			cfg.tail_bits = TAIL_RST;
			cfg.attempt_limit = LIMIT_RST;
			cfg.exponent_cap = CAP_RST;
			line_phase = PHASE_IDLE;
			count_left = '0;
			bits_sent = '0;
			collisions = '0;
			expected_status.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite)
					write_reg(paddr[APB_ADDR_W-1:2], pwdata);
				else if (prdata !== reg_value(paddr[APB_ADDR_W-1:2]))
					flag($sformatf("register %0d reads 0x%h, want 0x%h", paddr[APB_ADDR_W-1:2],
						prdata, reg_value(paddr[APB_ADDR_W-1:2])));
			end
			if (m_tvalid && m_tready)
				check_status(m_tdata);
			if (s_tvalid && s_tready)
				expected_status.push_back(advance_bit_time(s_tdata[ITEM_W-1:0]));
			pending = expected_status.size();
		end
	end

endmodule

// ===== tb/csma_cd_transmit_backoff_test.sv =====
`timescale 1ns / 100ps
module csma_cd_transmit_backoff_test;
	import csmab_pkg::*;

	// Abort when no transaction of any kind completes for this many cycles
	localparam int STALL_LIMIT = 20000;
	// Long receiver hold-off, long enough to back the input up
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_PHASES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// [0] frame_waiting, [1] carrier_sensed, [11:2] random_draw, [15:12] zero
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [2:0] phase, [3] transmitting, [4] sent_ok, [5] gave_up,
	// [10:6] attempt_count, [15:11] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int pending;
	int failures;
	int quiet_cycles = 0;

	// Idle controls shared with the driver and the receiver
	logic tx_idle_on = 1'b0;
	logic rx_idle_on = 1'b0;
	logic hold_req = 1'b0;

	csma_cd_transmit_backoff i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	csma_cd_backoff_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pending  (pending),
		.failures (failures)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: count cycles in which nothing at all is handed over
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("csma_cd_transmit_backoff_test: FAIL");
			$finish;
		end
	end

	// Receiver: random stalls in bursts, plus one long hold-off on request.
	// The hold is counted here so the sender keeps offering meanwhile.
	initial begin : result_sink
		int   burst_left;
		int   hold_left;
		logic hold_taken;
		burst_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (burst_left > 0) begin
				m_tready <= 1'b0;
				burst_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_on && $urandom_range(0, 7) == 0)
					burst_left = $urandom_range(1, 14);
			end
		end
	end

	// Offer one bit time; return at the falling edge after the transaction,
	// with tvalid still high so back-to-back items never toggle it.
	task automatic send_bit(input logic waiting, input logic carrier,
		input logic [DRAW_W-1:0] draw);
		item_t it;
		int    gap;
		it.frame_waiting = waiting;
		it.carrier_sensed = carrier;
		it.random_draw = draw;
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'(it);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	// Hold the input quiet until every predicted result has been returned
	task automatic drain();
		stop_sending();
		while (pending != 0) @(negedge clk);
		// cover the two-stage pipeline before touching registers
		repeat (3) @(negedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read(input logic [REG_IDX_W-1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Put random junk above the field so the register masking is exercised
	function automatic logic [APB_DATA_W-1:0] noisy(input logic [APB_DATA_W-1:0] field,
		input int w);
		logic [APB_DATA_W-1:0] junk;
		junk = $urandom();
		return (junk << w) | field;
	endfunction

	function automatic cfg_t make_cfg(input int gap, input int jam, input int slot,
		input int span, input int tail, input int limit, input int cap);
		cfg_t c;
		c.gap_bits = LEN_W'(gap);
		c.jam_bits = LEN_W'(jam);
		c.slot_bits = LEN_W'(slot);
		c.span_bits = LEN_W'(span);
		c.tail_bits = TAIL_W'(tail);
		c.attempt_limit = LIMIT_W'(limit);
		c.exponent_cap = CAP_W'(cap);
		return c;
	endfunction

	// Write every register, then poke the unused index, then read all back
	task automatic load_cfg(input cfg_t c);
		apb_write(REG_GAP, noisy(APB_DATA_W'(c.gap_bits), LEN_W));
		apb_write(REG_JAM, noisy(APB_DATA_W'(c.jam_bits), LEN_W));
		apb_write(REG_SLOT, noisy(APB_DATA_W'(c.slot_bits), LEN_W));
		apb_write(REG_SPAN, noisy(APB_DATA_W'(c.span_bits), LEN_W));
		apb_write(REG_TAIL, noisy(APB_DATA_W'(c.tail_bits), TAIL_W));
		apb_write(REG_LIMIT, noisy(APB_DATA_W'(c.attempt_limit), LIMIT_W));
		apb_write(REG_CAP, noisy(APB_DATA_W'(c.exponent_cap), CAP_W));
		apb_write(REG_CAP + 1'b1, $urandom());
		for (int i = 0; i <= REG_CAP; i++)
			apb_read(REG_IDX_W'(i));
	endtask

	// Random line activity: carrier comes in short busy bursts so that
	// listening usually gets through its gap and transmits meet collisions.
	task automatic run_bits(input int count, input int carrier_pct, input int waiting_pct);
		int               busy_left;
		logic [DRAW_W-1:0] draw;
		logic             carrier;
		busy_left = 0;
		for (int i = 0; i < count; i++) begin
			if (busy_left == 0 && $urandom_range(0, 99) < carrier_pct)
				busy_left = $urandom_range(1, 4);
			carrier = (busy_left != 0);
			if (busy_left != 0)
				busy_left--;
			case ($urandom_range(0, 7))
				0: draw = '0;
				1: draw = '1;
				default: draw = DRAW_W'($urandom_range(0, 1023));
			endcase
			send_bit($urandom_range(0, 99) < waiting_pct, carrier, draw);
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		int   carrier_pct;
		int   limit;
		int   cap;
		int   slot;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values read back, then traffic at the default timing
		for (int i = 0; i <= REG_CAP; i++)
			apb_read(REG_IDX_W'(i));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_bits(150, 2, 90);
		drain();

		// All lengths, limit and cap at zero
		load_cfg(make_cfg(0, 0, 0, 0, 0, 0, 0));
		send_bit(1'b0, 1'b0, 10'd0);     // idle, nothing queued
		send_bit(1'b0, 1'b1, 10'd1023);  // carrier alone does not wake idle
		send_bit(1'b1, 1'b1, 10'd0);     // queued frame: go listen
		send_bit(1'b0, 1'b1, 10'd512);   // carrier reloads a zero gap
		send_bit(1'b0, 1'b0, 10'd0);     // zero gap runs out in one bit
		send_bit(1'b0, 1'b1, 10'd0);     // no window, no tail: done at once
		drain();

		// Zero attempt limit: the first collision drops the frame
		load_cfg(make_cfg(0, 0, 0, 2, 1, 0, 0));
		send_bit(1'b1, 1'b0, 10'd0);
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b1, 10'd0);     // collide inside the window
		send_bit(1'b1, 1'b0, 10'd1023);  // jam over, give up
		drain();

		// Widest limit and cap; zero-slot backoff, then a three-slot one
		load_cfg(make_cfg(1, 1, 1, 1, 4095, 31, 15));
		send_bit(1'b1, 1'b0, 10'd0);
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b1, 10'd0);
		send_bit(1'b0, 1'b0, 10'd1022);  // draw masked to zero: listen again
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b1, 10'd0);
		send_bit(1'b0, 1'b0, 10'd1023);  // two bits of draw: three slots
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b0, 10'd0);
		send_bit(1'b0, 1'b1, 10'd0);     // inside the window: a third collision
		drain();
		// shrink the tail while jamming; the next bit ends the jam and listens again
		load_cfg(make_cfg(1, 1, 1, 1, 0, 31, 15));
		send_bit(1'b0, 1'b1, 10'd0);
		drain();

		// Upper extremes; a zero cap keeps the long slot from ever being used
		load_cfg(make_cfg(1023, 1023, 1023, 1023, 4095, 31, 0));
		run_bits(120, 0, 80);
		drain();

		// Random settings with small lengths so frames turn over quickly
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			limit = (p % 3 == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
			cap = $urandom_range(0, 3);
			slot = $urandom_range(0, 4);
			if (p == 4) begin
				// wide exponent: keep the slot and limit small to bound backoff
				cap = $urandom_range(11, 15);
				slot = 1;
				limit = $urandom_range(1, 11);
			end
			c = make_cfg($urandom_range(0, 6), $urandom_range(0, 4), slot,
				$urandom_range(0, 8), $urandom_range(0, 12), limit, cap);
			load_cfg(c);
			case ($urandom_range(0, 3))
				0: carrier_pct = 3;
				1: carrier_pct = 10;
				2: carrier_pct = 25;
				default: carrier_pct = 50;
			endcase
			// back up the pipeline once with a long receiver hold-off
			if (p == 2)
				hold_req = 1'b1;
			run_bits(100, carrier_pct, (p == 7) ? 50 : 90);
			drain();
		end

		// Closing stretch at full rate on both sides
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		load_cfg(make_cfg(2, 1, 1, 3, 5, 3, 2));
		run_bits(100, 15, 95);
		drain();
		repeat (8) @(posedge clk);

		if (failures == 0)
			$display("csma_cd_transmit_backoff_test: PASS");
		else
			$display("csma_cd_transmit_backoff_test: FAIL");
		$finish;
	end

endmodule
